>>> src/adf_pkg.sv
// Shared types, constants and helpers for the ASCII decimal to fixed point converter.
package adf_pkg;

  // Result value width, fixed by the output format.
  localparam int VALUE_W = 51;

  // Character codes recognized by the classifier.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // The first dropped fraction digit rounds up from this value on.
  localparam logic [3:0] ROUND_DIGIT = 4'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TOK_DIGIT,
    TOK_MINUS,
    TOK_DOT,
    TOK_OTHER
  } tok_kind_t;

  // One classified character as it travels from front end to back end.
  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } out_item_t;

  // Ten to the n, wrapping at 64 bits; used for elaboration-time constants.
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

>>> src/adf_front.sv
// Front end: classifies each request's character and queues it for the back end.
module adf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  adf_pkg::in_item_t in_item,
  output logic             tok_valid,
  input  logic             tok_ready,
  output adf_pkg::tok_t    tok
);

  adf_pkg::tok_t tok_in;
  adf_pkg::tok_t q_mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          push, pop;

  // Sort the character into digit, minus, dot or anything else.
  always_comb begin
    tok_in.last  = in_item.last;
    tok_in.digit = 4'(in_item.char_code - adf_pkg::CHAR_ZERO);
    priority if (in_item.char_code >= adf_pkg::CHAR_ZERO &&
                 in_item.char_code <= adf_pkg::CHAR_NINE) begin
      tok_in.kind = adf_pkg::TOK_DIGIT;
    end else if (in_item.char_code == adf_pkg::CHAR_MINUS) begin
      tok_in.kind = adf_pkg::TOK_MINUS;
    end else if (in_item.char_code == adf_pkg::CHAR_DOT) begin
      tok_in.kind = adf_pkg::TOK_DOT;
    end else begin
      tok_in.kind = adf_pkg::TOK_OTHER;
    end
  end

  // Two-entry queue handshakes.
  assign in_ready  = (count_r != 2'd2);
  assign tok_valid = (count_r != 2'd0);
  assign tok       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= tok_in;
    end
  end

  // An empty or full queue has equal read and write pointers.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

>>> src/adf_back.sv
// Back end: builds sign, integer and fraction parts and snapshots them at string end.
module adf_back #(
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 6
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    tok_valid,
  output logic                                                    tok_ready,
  input  adf_pkg::tok_t                                           tok,
  output logic                                                    snap_valid,
  input  logic                                                    snap_ready,
  output logic [$clog2(adf_pkg::pow10(INT_DIGITS))-1:0]           snap_int,
  output logic [$clog2(adf_pkg::pow10(FRAC_DIGITS))-1:0]          snap_frac,
  output logic [$clog2(FRAC_DIGITS+2)-1:0]                        snap_cnt,
  output logic                                                    snap_round,
  output logic                                                    snap_neg,
  output adf_pkg::status_t                                        snap_status
);

  localparam int IW = $clog2(adf_pkg::pow10(INT_DIGITS));
  localparam int FW = $clog2(adf_pkg::pow10(FRAC_DIGITS));
  localparam int CW = $clog2(FRAC_DIGITS + 2);
  localparam logic [IW-1:0] IMAX = IW'(adf_pkg::pow10(INT_DIGITS) - 64'd1);
  localparam logic [CW-1:0] FRAC_N = CW'(FRAC_DIGITS);

  logic              neg_r, neg_upd, neg_nxt;
  logic              at_start_r, at_start_nxt;
  logic              in_frac_r, in_frac_upd, in_frac_nxt;
  logic [IW-1:0]     int_r, int_upd, int_nxt;
  logic [FW-1:0]     frac_r, frac_upd, frac_nxt;
  logic [CW-1:0]     cnt_r, cnt_upd, cnt_nxt;
  logic              round_r, round_upd, round_nxt;
  adf_pkg::status_t  err_r, err_upd, err_nxt;
  logic [IW+3:0]     int_prod;
  logic [FW+3:0]     frac_prod;
  logic              tok_take, snap_load;
  logic              snap_valid_r, snap_valid_nxt;
  logic [IW-1:0]     snap_int_r;
  logic [FW-1:0]     snap_frac_r;
  logic [CW-1:0]     snap_cnt_r;
  logic              snap_round_r, snap_neg_r;
  adf_pkg::status_t  snap_status_r;

  // A final character waits until the snapshot register can take it.
  assign tok_ready = !tok.last || !snap_valid_r || snap_ready;
  assign tok_take  = tok_valid && tok_ready;
  assign snap_load = tok_take && tok.last;

  // Multiply-by-ten-add for both parts.
  assign int_prod  = ({4'd0, int_r} << 3) + ({4'd0, int_r} << 1) + (IW+4)'(tok.digit);
  assign frac_prod = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1) + (FW+4)'(tok.digit);

  // Apply one character to the running state.
  always_comb begin
    neg_upd     = neg_r;
    in_frac_upd = in_frac_r;
    int_upd     = int_r;
    frac_upd    = frac_r;
    cnt_upd     = cnt_r;
    round_upd   = round_r;
    err_upd     = err_r;
    if (err_r != adf_pkg::ST_INVALID) begin
      unique case (tok.kind)
        adf_pkg::TOK_MINUS: begin
          if (at_start_r) begin
            neg_upd = 1'b1;
          end else if (err_r == adf_pkg::ST_OK) begin
            err_upd = adf_pkg::ST_INVALID;
          end
        end
        adf_pkg::TOK_DOT: begin
          if (!in_frac_r) begin
            in_frac_upd = 1'b1;
          end else if (err_r == adf_pkg::ST_OK) begin
            err_upd = adf_pkg::ST_INVALID;
          end
        end
        adf_pkg::TOK_DIGIT: begin
          if (!in_frac_r) begin
            if (int_prod > (IW+4)'(IMAX)) begin
              int_upd = IMAX;
              if (err_r == adf_pkg::ST_OK) begin
                err_upd = adf_pkg::ST_OVERFLOW;
              end
            end else begin
              int_upd = IW'(int_prod);
            end
          end else if (cnt_r < FRAC_N) begin
            frac_upd = FW'(frac_prod);
            cnt_upd  = cnt_r + CW'(1);
          end else if (cnt_r == FRAC_N) begin
            round_upd = (tok.digit >= adf_pkg::ROUND_DIGIT);
            cnt_upd   = cnt_r + CW'(1);
          end
        end
        default: begin
          if (err_r == adf_pkg::ST_OK) begin
            err_upd = adf_pkg::ST_INVALID;
          end
        end
      endcase
    end
  end

  // Next state: hold, update, or clear after the final character.
  always_comb begin
    neg_nxt      = neg_r;
    at_start_nxt = at_start_r;
    in_frac_nxt  = in_frac_r;
    int_nxt      = int_r;
    frac_nxt     = frac_r;
    cnt_nxt      = cnt_r;
    round_nxt    = round_r;
    err_nxt      = err_r;
    if (snap_load) begin
      neg_nxt      = 1'b0;
      at_start_nxt = 1'b1;
      in_frac_nxt  = 1'b0;
      int_nxt      = '0;
      frac_nxt     = '0;
      cnt_nxt      = '0;
      round_nxt    = 1'b0;
      err_nxt      = adf_pkg::ST_OK;
    end else if (tok_take) begin
      neg_nxt      = neg_upd;
      at_start_nxt = 1'b0;
      in_frac_nxt  = in_frac_upd;
      int_nxt      = int_upd;
      frac_nxt     = frac_upd;
      cnt_nxt      = cnt_upd;
      round_nxt    = round_upd;
      err_nxt      = err_upd;
    end
  end

  assign snap_valid_nxt = snap_load || (snap_valid_r && !snap_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r        <= 1'b0;
      at_start_r   <= 1'b1;
      in_frac_r    <= 1'b0;
      int_r        <= '0;
      frac_r       <= '0;
      cnt_r        <= '0;
      round_r      <= 1'b0;
      err_r        <= adf_pkg::ST_OK;
      snap_valid_r <= 1'b0;
    end else begin
      neg_r        <= neg_nxt;
      at_start_r   <= at_start_nxt;
      in_frac_r    <= in_frac_nxt;
      int_r        <= int_nxt;
      frac_r       <= frac_nxt;
      cnt_r        <= cnt_nxt;
      round_r      <= round_nxt;
      err_r        <= err_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  // Snapshot of the finished string for the finishing pipeline.
  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_int_r    <= int_upd;
      snap_frac_r   <= frac_upd;
      snap_cnt_r    <= cnt_upd;
      snap_round_r  <= round_upd;
      snap_neg_r    <= neg_upd;
      snap_status_r <= err_upd;
    end
  end

  assign snap_valid  = snap_valid_r;
  assign snap_int    = snap_int_r;
  assign snap_frac   = snap_frac_r;
  assign snap_cnt    = snap_cnt_r;
  assign snap_round  = snap_round_r;
  assign snap_neg    = snap_neg_r;
  assign snap_status = snap_status_r;

  // The integer part never passes its saturation limit.
  a_int_limit: assert property (@(posedge clk) disable iff (!rst_n)
    int_r <= IMAX)
    else $error("integer part above saturation limit");

  // A final character leaves the running state cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load |=> (at_start_r && !in_frac_r && int_r == '0 && err_r == adf_pkg::ST_OK))
    else $error("state not cleared after final character");

endmodule

>>> src/adf_finish.sv
// Finishing pipeline: scales, sums, rounds, saturates and signs the result.
module adf_finish #(
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 6
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           snap_valid,
  output logic                                           snap_ready,
  input  logic [$clog2(adf_pkg::pow10(INT_DIGITS))-1:0]  snap_int,
  input  logic [$clog2(adf_pkg::pow10(FRAC_DIGITS))-1:0] snap_frac,
  input  logic [$clog2(FRAC_DIGITS+2)-1:0]               snap_cnt,
  input  logic                                           snap_round,
  input  logic                                           snap_neg,
  input  adf_pkg::status_t                               snap_status,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output adf_pkg::out_item_t                             out_item
);

  localparam int IW = $clog2(adf_pkg::pow10(INT_DIGITS));
  localparam int FW = $clog2(adf_pkg::pow10(FRAC_DIGITS));
  localparam int CW = $clog2(FRAC_DIGITS + 2);
  localparam int SUM_DIGITS = INT_DIGITS + FRAC_DIGITS;
  localparam int MW = (SUM_DIGITS > 19) ? 64 : $clog2(adf_pkg::pow10(SUM_DIGITS));
  localparam int EW = (MW > adf_pkg::VALUE_W) ? MW : adf_pkg::VALUE_W;
  localparam logic [MW-1:0] P10F    = MW'(adf_pkg::pow10(FRAC_DIGITS));
  localparam logic [MW-1:0] MAG_MAX = MW'(adf_pkg::pow10(SUM_DIGITS) - 64'd1);

  logic [FW-1:0]      scale_tab [2**CW];
  logic               m_valid_r, m_valid_nxt;
  logic [MW-1:0]      m_int_r;
  logic [FW-1:0]      m_frac_r;
  logic               m_round_r, m_neg_r;
  adf_pkg::status_t   m_status_r;
  logic               s_valid_r, s_valid_nxt;
  logic [MW-1:0]      s_mag_r;
  logic               s_round_r, s_neg_r;
  adf_pkg::status_t   s_status_r;
  logic               out_valid_r, out_valid_nxt;
  adf_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_free, s_free, m_free;
  logic [MW-1:0]      mag;
  logic [EW-1:0]      mag_ext;
  adf_pkg::status_t   st;

  // Scale for fewer than the full count of fraction digits.
  for (genvar g = 0; g < 2**CW; g++) begin : g_scale
    if (g < FRAC_DIGITS) begin : g_pow
      assign scale_tab[g] = FW'(adf_pkg::pow10(FRAC_DIGITS - g));
    end else begin : g_one
      assign scale_tab[g] = FW'(1);
    end
  end

  // Stage readiness, back to front.
  assign out_free   = !out_valid_r || out_ready;
  assign s_free     = !s_valid_r || out_free;
  assign m_free     = !m_valid_r || s_free;
  assign snap_ready = m_free;

  assign m_valid_nxt   = snap_valid || (m_valid_r && !s_free);
  assign s_valid_nxt   = m_valid_r || (s_valid_r && !out_free);
  assign out_valid_nxt = s_valid_r || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (m_free) begin
        m_valid_r <= m_valid_nxt;
      end else begin
        m_valid_r <= m_valid_r;
      end
      s_valid_r   <= s_free ? s_valid_nxt : s_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Multiply stage: integer part times ten to the fraction digits, fraction rescaled.
  always_ff @(posedge clk) begin
    if (snap_valid && m_free) begin
      m_int_r    <= MW'(snap_int) * P10F;
      m_frac_r   <= snap_frac * scale_tab[snap_cnt];
      m_round_r  <= snap_round;
      m_neg_r    <= snap_neg;
      m_status_r <= snap_status;
    end
  end

  // Sum stage: full magnitude before rounding.
  always_ff @(posedge clk) begin
    if (m_valid_r && s_free) begin
      s_mag_r    <= m_int_r + MW'(m_frac_r);
      s_round_r  <= m_round_r;
      s_neg_r    <= m_neg_r;
      s_status_r <= m_status_r;
    end
  end

  // Round, saturate and apply the sign.
  always_comb begin
    unique case (s_status_r)
      adf_pkg::ST_INVALID: begin
        mag = '0;
        st  = adf_pkg::ST_INVALID;
      end
      adf_pkg::ST_OVERFLOW: begin
        mag = MAG_MAX;
        st  = adf_pkg::ST_OVERFLOW;
      end
      default: begin
        if (s_round_r && s_mag_r >= MAG_MAX) begin
          mag = MAG_MAX;
          st  = adf_pkg::ST_OVERFLOW;
        end else begin
          mag = s_mag_r + MW'(s_round_r);
          st  = adf_pkg::ST_OK;
        end
      end
    endcase
    mag_ext             = EW'(mag);
    out_item_nxt.value  = adf_pkg::VALUE_W'(s_neg_r ? (~mag_ext + EW'(1)) : mag_ext);
    out_item_nxt.status = st;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (s_valid_r && out_free) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // An invalid string always reports zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == adf_pkg::ST_INVALID) |-> (out_item_r.value == '0))
    else $error("invalid string with nonzero value");

  // A sum stage entry blocked by the output register is kept.
  a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && !out_free) |=> s_valid_r)
    else $error("sum stage entry dropped under stall");

endmodule

>>> src/ascii_decimal_to_fixed_point.sv
// Top level of the ASCII decimal string to fixed point converter.
//
//   Port group  Dir  Handshake              Payload
//   in_         in   in_valid / in_ready    adf_pkg::in_item_t  (char_code, last)
//   out_        out  out_valid / out_ready  adf_pkg::out_item_t (value, status)
//
// One character request is taken per cycle while the snapshot register is not held;
// the back end's one multiply-by-ten-add step per character sets that figure.
// After its final character is accepted, a result passes in order through the
// queue, snapshot, multiply stage, sum stage and output register.
// Reset is synchronous; the block takes requests in the first cycle after
// rst_n rises. Low out_ready holds the output register, then the two
// finishing stages and the snapshot; in_ready drops once the two-entry queue fills.
module ascii_decimal_to_fixed_point #(
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  adf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output adf_pkg::out_item_t out_item
);

  localparam int IW = $clog2(adf_pkg::pow10(INT_DIGITS));
  localparam int FW = $clog2(adf_pkg::pow10(FRAC_DIGITS));
  localparam int CW = $clog2(FRAC_DIGITS + 2);

  logic             tok_valid, tok_ready;
  adf_pkg::tok_t    tok;
  logic             snap_valid, snap_ready;
  logic [IW-1:0]    snap_int;
  logic [FW-1:0]    snap_frac;
  logic [CW-1:0]    snap_cnt;
  logic             snap_round, snap_neg;
  adf_pkg::status_t snap_status;

  // Character classification and queue.
  adf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // Accumulation of sign, integer and fraction parts.
  adf_back #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .tok         (tok),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_int    (snap_int),
    .snap_frac   (snap_frac),
    .snap_cnt    (snap_cnt),
    .snap_round  (snap_round),
    .snap_neg    (snap_neg),
    .snap_status (snap_status)
  );

  // Scaling, rounding and output register.
  adf_finish #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_int    (snap_int),
    .snap_frac   (snap_frac),
    .snap_cnt    (snap_cnt),
    .snap_round  (snap_round),
    .snap_neg    (snap_neg),
    .snap_status (snap_status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
